/* rtl/xmodem_block_receiver_macros.svh */
// Assertion macros shared by the receiver RTL.
// XMBR_ASSERT_IMPL checks a same-cycle implication, XMBR_ASSERT_NEXT a
// next-cycle one. Both compile away when SYNTH is defined.
`ifndef XMODEM_BLOCK_RECEIVER_MACROS_SVH
`define XMODEM_BLOCK_RECEIVER_MACROS_SVH
`ifndef SYNTH
`define XMBR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define XMBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define XMBR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define XMBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/xmbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmbr_pkg
// Shared types, codes and the CRC-16 byte update of the block receiver.
// ----------------------------------------------------------------------------
package xmbr_pkg;

   // input action codes; code 3 means nothing
   localparam logic [1:0] ACT_BYTE   = 2'd0;
   localparam logic [1:0] ACT_TICK   = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // header bytes
   localparam logic [7:0] HDR_SOH_BYTE = 8'h01;
   localparam logic [7:0] HDR_STX_BYTE = 8'h02;
   localparam logic [7:0] HDR_EOT_BYTE = 8'h04;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EOT     = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_BADHDR  = 3'd3;
   localparam logic [2:0] ST_DUP     = 3'd4;
   localparam logic [2:0] ST_SEQ     = 3'd5;
   localparam logic [2:0] ST_CORRUPT = 3'd6;
   localparam logic [2:0] ST_QUIT    = 3'd7;

   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;

   localparam logic [10:0] LEN_NONE  = 11'd0;
   localparam logic [10:0] LEN_SHORT = 11'd128;
   localparam logic [10:0] LEN_LONG  = 11'd1024;

   // register indexes (word address bit 2)
   localparam logic REG_CRC_CHECK = 1'b0;
   localparam logic REG_TIMEOUT   = 1'b1;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [1:0] {
      CLS_BYTE   = 2'd0,
      CLS_TICK   = 2'd1,
      CLS_CANCEL = 2'd2
   } cls_type;

   typedef enum logic [1:0] {
      HDR_SOH = 2'd0,
      HDR_STX = 2'd1,
      HDR_EOT = 2'd2,
      HDR_BAD = 2'd3
   } hdr_type;

   // one classified word as it sits in the queue
   typedef struct packed {
      cls_type    cls;
      logic [7:0] rx_byte;
      hdr_type    hdr;
      logic       num_dup;    // byte + 1 equals the block sought
      logic       num_match;  // byte equals the block sought
      logic       compl_ok;   // inverted byte equals the block sought
   } op_type;

   // CRC-16/XMODEM, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/xmbr_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmbr_req_if
// Input channel: received bytes, ticks and cancel requests.
// ----------------------------------------------------------------------------
interface xmbr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;
   logic [7:0] expected_block;

   modport source (output valid, action, rx_byte, expected_block, input ready);
   modport sink   (input valid, action, rx_byte, expected_block, output ready);
endinterface

/* rtl/xmbr_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmbr_rsp_if
// Result channel: payload bytes and block status words.
// ----------------------------------------------------------------------------
interface xmbr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_out;
   logic [9:0]  byte_index;
   logic [2:0]  status;
   logic [10:0] block_length;

   modport source (output valid, kind, data_out, byte_index, status, block_length,
                   input ready);
   modport sink   (input valid, kind, data_out, byte_index, status, block_length,
                   output ready);
endinterface

/* rtl/xmbr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmbr_front
// Accepts input words, drops unused action codes and pre-decodes the byte.
// ----------------------------------------------------------------------------
module xmbr_front (
   xmbr_req_if.sink         req_if,
   input  logic             q_full,
   output logic             push,
   output xmbr_pkg::op_type op
);
   import xmbr_pkg::*;

   logic [7:0] inc_byte;

   assign req_if.ready = !q_full;
   assign push = req_if.valid && !q_full && (req_if.action != ACT_UNUSED);

   assign inc_byte = req_if.rx_byte + 8'd1;

   always_comb begin
      op.rx_byte   = req_if.rx_byte;
      op.num_dup   = (inc_byte == req_if.expected_block);
      op.num_match = (req_if.rx_byte == req_if.expected_block);
      op.compl_ok  = (~req_if.rx_byte == req_if.expected_block);

      unique case (req_if.action)
         ACT_TICK:   op.cls = CLS_TICK;
         ACT_CANCEL: op.cls = CLS_CANCEL;
         default:    op.cls = CLS_BYTE;
      endcase

      unique case (req_if.rx_byte)
         HDR_SOH_BYTE: op.hdr = HDR_SOH;
         HDR_STX_BYTE: op.hdr = HDR_STX;
         HDR_EOT_BYTE: op.hdr = HDR_EOT;
         default:      op.hdr = HDR_BAD;
      endcase
   end

endmodule

/* rtl/xmbr_queue.sv */
`timescale 1ns / 1ps
`include "xmodem_block_receiver_macros.svh"
// ----------------------------------------------------------------------------
// xmbr_queue
// Small FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module xmbr_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xmbr_pkg::op_type din,
   input  logic             pop,
   output xmbr_pkg::op_type dout,
   output logic             not_empty,
   output logic             full
);
   import xmbr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   op_type        slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign dout      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   `XMBR_ASSERT_IMPL(a_no_push_full, clock, reset, full, !push, "push into full queue")
   `XMBR_ASSERT_IMPL(a_no_pop_empty, clock, reset, !not_empty, !pop, "pop from empty queue")
   `XMBR_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise")

endmodule

/* rtl/xmbr_back.sv */
`timescale 1ns / 1ps
`include "xmodem_block_receiver_macros.svh"
// ----------------------------------------------------------------------------
// xmbr_back
// Block parser: phase machine, check accumulators, timeout and result register.
// ----------------------------------------------------------------------------
module xmbr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             crc_check,
   input  logic [23:0]      timeout_ticks,
   input  xmbr_pkg::op_type op,
   input  logic             q_valid,
   output logic             pop,
   xmbr_rsp_if.source       rsp_if
);
   import xmbr_pkg::*;

   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_NUM    = 6'b000010,
      PH_COMPL  = 6'b000100,
      PH_DATA   = 6'b001000,
      PH_CHK1   = 6'b010000,
      PH_CHK2   = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [10:0] byte_count_ff, byte_count_in;
   logic        long_block_ff, long_block_in;
   logic [15:0] crc_accum_ff, crc_accum_in;
   logic [7:0]  sum_accum_ff, sum_accum_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [23:0] idle_ticks_ff, idle_ticks_in;
   logic        quit_pending_ff, quit_pending_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [9:0]  index_ff, index_in;
   logic [2:0]  status_ff, status_in;
   logic [10:0] length_ff, length_in;

   logic        emit_st, emit_dat;
   logic        load_rsp;
   logic [2:0]  st_code;
   logic [10:0] cur_len;
   logic [10:0] count_inc;
   logic [23:0] idle_inc;
   logic [23:0] limit;

   assign pop      = q_valid && (!rsp_valid_ff || rsp_if.ready);
   assign load_rsp = pop && (emit_st || emit_dat);
   assign limit    = (timeout_ticks == '0) ? 24'd1 : timeout_ticks;
   assign idle_inc = idle_ticks_ff + 24'd1;
   assign count_inc = byte_count_ff + 11'd1;
   assign cur_len  = (phase_ff == PH_HEADER) ? LEN_NONE
                     : (long_block_ff ? LEN_LONG : LEN_SHORT);

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      long_block_in   = long_block_ff;
      crc_accum_in    = crc_accum_ff;
      sum_accum_in    = sum_accum_ff;
      crc_high_in     = crc_high_ff;
      idle_ticks_in   = idle_ticks_ff;
      quit_pending_in = quit_pending_ff;
      emit_st         = 1'b0;
      emit_dat        = 1'b0;
      st_code         = ST_OK;

      priority if (phase_ff == PH_HEADER && quit_pending_ff) begin
         quit_pending_in = 1'b0;
         emit_st         = 1'b1;
         st_code         = ST_QUIT;
      end else if (op.cls == CLS_CANCEL) begin
         if (phase_ff == PH_HEADER) begin
            emit_st = 1'b1;
            st_code = ST_QUIT;
         end else begin
            quit_pending_in = 1'b1;
         end
      end else if (op.cls == CLS_TICK) begin
         idle_ticks_in = idle_inc;
         if (idle_inc >= limit) begin
            emit_st = 1'b1;
            st_code = ST_TIMEOUT;
         end
      end else begin
         idle_ticks_in = '0;
         unique case (phase_ff)
            PH_NUM: begin
               if (op.num_dup) begin
                  emit_st = 1'b1;
                  st_code = ST_DUP;
               end else if (!op.num_match) begin
                  emit_st = 1'b1;
                  st_code = ST_SEQ;
               end else begin
                  phase_in = PH_COMPL;
               end
            end
            PH_COMPL: begin
               if (!op.compl_ok) begin
                  emit_st = 1'b1;
                  st_code = ST_CORRUPT;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               emit_dat      = 1'b1;
               crc_accum_in  = crc16_byte(crc_accum_ff, op.rx_byte);
               sum_accum_in  = sum_accum_ff + op.rx_byte;
               byte_count_in = count_inc;
               if (count_inc >= cur_len) begin
                  phase_in = PH_CHK1;
               end
            end
            PH_CHK1: begin
               if (crc_check) begin
                  crc_high_in = op.rx_byte;
                  phase_in    = PH_CHK2;
               end else begin
                  emit_st = 1'b1;
                  st_code = (sum_accum_ff == op.rx_byte) ? ST_OK : ST_CORRUPT;
               end
            end
            PH_CHK2: begin
               emit_st = 1'b1;
               st_code = ({crc_high_ff, op.rx_byte} == crc_accum_ff) ? ST_OK : ST_CORRUPT;
            end
            default: begin
               // awaiting a header
               unique case (op.hdr)
                  HDR_SOH, HDR_STX: begin
                     long_block_in = (op.hdr == HDR_STX);
                     byte_count_in = '0;
                     crc_accum_in  = '0;
                     sum_accum_in  = '0;
                     crc_high_in   = '0;
                     phase_in      = PH_NUM;
                  end
                  HDR_EOT: begin
                     emit_st = 1'b1;
                     st_code = ST_EOT;
                  end
                  default: begin
                     emit_st = 1'b1;
                     st_code = ST_BADHDR;
                  end
               endcase
            end
         endcase
      end

      if (emit_st) begin
         phase_in      = PH_HEADER;
         byte_count_in = '0;
         idle_ticks_in = '0;
      end
   end

   // result word
   always_comb begin
      kind_in   = kind_ff;
      data_in   = data_ff;
      index_in  = index_ff;
      status_in = status_ff;
      length_in = length_ff;
      if (emit_st) begin
         kind_in   = KIND_STATUS;
         data_in   = '0;
         index_in  = '0;
         status_in = st_code;
         length_in = cur_len;
      end else if (emit_dat) begin
         kind_in   = KIND_DATA;
         data_in   = op.rx_byte;
         index_in  = byte_count_ff[9:0];
         status_in = ST_OK;
         length_in = cur_len;
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         byte_count_ff   <= '0;
         long_block_ff   <= 1'b0;
         crc_accum_ff    <= '0;
         sum_accum_ff    <= '0;
         crc_high_ff     <= '0;
         idle_ticks_ff   <= '0;
         quit_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff        <= phase_in;
            byte_count_ff   <= byte_count_in;
            long_block_ff   <= long_block_in;
            crc_accum_ff    <= crc_accum_in;
            sum_accum_ff    <= sum_accum_in;
            crc_high_ff     <= crc_high_in;
            idle_ticks_ff   <= idle_ticks_in;
            quit_pending_ff <= quit_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         index_ff  <= index_in;
         status_ff <= status_in;
         length_ff <= length_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = kind_ff;
   assign rsp_if.data_out     = data_ff;
   assign rsp_if.byte_index   = index_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.block_length = length_ff;

   `XMBR_ASSERT_NEXT(a_result_loaded, clock, reset, load_rsp, rsp_valid_ff, "result word lost")
   `XMBR_ASSERT_IMPL(a_header_count, clock, reset, phase_ff == PH_HEADER,
                     byte_count_ff == '0, "byte count not cleared at header")
   `XMBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_if.ready,
                     rsp_valid_ff, "result word dropped while stalled")

endmodule

/* rtl/xmodem_block_receiver.sv */
// A word taken from req_if goes into the queue; the back end pops words in order and, where
// a word yields one, loads the registered result word. One word is taken per cycle while the
// queue has room; the back-end phase machine handles one queued word a cycle. An untaken
// result word holds the back end; the queue absorbs up to QUEUE_DEPTH (default 4) words.
// Reset (synchronous, active high) clears the queue, the phase machine to awaiting header,
// and sets crc_check to 1 and timeout_ticks to 1000.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_block_receiver
// XMODEM block parser with CRC-16 or checksum check and an APB register port.
// ----------------------------------------------------------------------------
module xmodem_block_receiver #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   xmbr_req_if.sink    req_if,
   xmbr_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import xmbr_pkg::*;

   // configuration registers
   logic        crc_check_ff, crc_check_in;
   logic [23:0] timeout_ticks_ff, timeout_ticks_in;
   logic        csr_write;

   // front end to queue to back end
   logic   push;
   logic   pop;
   logic   q_full;
   logic   q_not_empty;
   op_type op_push;
   op_type op_head;

   // ---------------------------------------------------------------------
   // APB: zero wait states, word address bit 2 picks the register
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      crc_check_in     = crc_check_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_CRC_CHECK: crc_check_in     = pwdata[0];
            default:       timeout_ticks_in = pwdata[23:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_check_ff     <= 1'b1;
         timeout_ticks_ff <= 24'd1000;
      end else begin
         crc_check_ff     <= crc_check_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TIMEOUT: prdata = {8'd0, timeout_ticks_ff};
         default:     prdata = {31'd0, crc_check_ff};
      endcase
   end

   // ---------------------------------------------------------------------
   // Front end: takes a word whenever the queue has room and pre-decodes
   // header class and block-number compares against expected_block
   // ---------------------------------------------------------------------
   xmbr_front u_front (
      .req_if (req_if),
      .q_full (q_full),
      .push   (push),
      .op     (op_push)
   );

   // ---------------------------------------------------------------------
   // Queue: decouples input acceptance from result back-pressure
   // ---------------------------------------------------------------------
   xmbr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din       (op_push),
      .pop       (pop),
      .dout      (op_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // ---------------------------------------------------------------------
   // Back end: phase machine, CRC/sum accumulators, idle tick counter,
   // deferred quit, and the registered result word
   // ---------------------------------------------------------------------
   xmbr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .crc_check     (crc_check_ff),
      .timeout_ticks (timeout_ticks_ff),
      .op            (op_head),
      .q_valid       (q_not_empty),
      .pop           (pop),
      .rsp_if        (rsp_if)
   );

endmodule
